@@ hw/rtl/sv32_page_table_walker_assert.svh @@
// ----------------------------------------------------------------------------
// Sv32 page table walker assertion macros
// Shared concurrent assertion forms, synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SV32_PAGE_TABLE_WALKER_ASSERT_SVH
`define SV32_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication.
`define SV32PTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sv32ptw: assertion failed");

// Next-cycle implication.
`define SV32PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sv32ptw: assertion failed");

`endif

@@ hw/rtl/sv32ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// sv32ptw_pkg
// Types and constants of the Sv32 page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package sv32ptw_pkg;

    localparam int unsigned VA_W    = 32;
    localparam int unsigned PA_W    = 34;
    localparam int unsigned PPN_W   = 22;
    localparam int unsigned VPN_W   = 10;
    localparam int unsigned PRIV_W  = 2;
    localparam int unsigned ENTRY_W = 32;

    // item codes
    localparam logic FUNC_REQ  = 1'b0;
    localparam logic FUNC_RSP  = 1'b1;
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [PRIV_W-1:0] PRIV_USER = 2'd0;

    // PTE bit positions
    localparam int unsigned PTE_V = 0;
    localparam int unsigned PTE_R = 1;
    localparam int unsigned PTE_W = 2;
    localparam int unsigned PTE_X = 3;
    localparam int unsigned PTE_U = 4;
    localparam int unsigned PTE_A = 6;
    localparam int unsigned PTE_D = 7;
    localparam int unsigned PTE_PPN_LSB = 10;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_L1   = 2'd1,
        PH_L2   = 2'd2
    } t_phase;

    typedef struct packed {
        logic               func;
        logic [VA_W-1:0]    virt_addr;
        logic               is_read;
        logic               is_write;
        logic               is_exec;
        logic               trans_on;
        logic [PRIV_W-1:0]  privilege;
        logic [PPN_W-1:0]   root_ppn;
        logic [ENTRY_W-1:0] entry_word;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic [PA_W-1:0]    read_addr;
        logic [PA_W-1:0]    phys_addr;
        logic               fault;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/sv32ptw_if.sv @@
// ----------------------------------------------------------------------------
// sv32ptw_if
// Valid/ready channels of the walker: request in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sv32ptw_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] virt_addr;
    logic        is_read;
    logic        is_write;
    logic        is_exec;
    logic        trans_on;
    logic [1:0]  privilege;
    logic [21:0] root_ppn;
    logic [31:0] entry_word;

    modport source (
        output valid, func, virt_addr, is_read, is_write, is_exec, trans_on,
               privilege, root_ppn, entry_word,
        input  ready
    );
    modport sink (
        input  valid, func, virt_addr, is_read, is_write, is_exec, trans_on,
               privilege, root_ppn, entry_word,
        output ready
    );
endinterface

interface sv32ptw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [33:0] read_addr;
    logic [33:0] phys_addr;
    logic        fault;

    modport source (
        output valid, kind, read_addr, phys_addr, fault,
        input  ready
    );
    modport sink (
        input  valid, kind, read_addr, phys_addr, fault,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/sv32ptw_walk.sv @@
// ----------------------------------------------------------------------------
// sv32ptw_walk
// Walk state and the one-step decision for a request or memory response.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sv32_page_table_walker_assert.svh"

module sv32ptw_walk
    import sv32ptw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output t_result      o_result
);

    t_phase            r_phase,  n_phase;
    logic [VA_W-1:0]   r_vaddr,  n_vaddr;
    logic [2:0]        r_access, n_access;
    logic [PRIV_W-1:0] r_priv,   n_priv;

    logic [ENTRY_W-1:0] e;
    logic [PPN_W-1:0]   ppn;
    logic               v, r, w, x;

    function automatic t_result leaf_check(
        input logic [ENTRY_W-1:0] pte,
        input logic [2:0]         acc,
        input logic [PRIV_W-1:0]  priv,
        input logic [PA_W-1:0]    paddr
    );
        t_result res;
        logic    rd, wr, ex, bad;
        rd  = acc[0];
        wr  = acc[1];
        ex  = acc[2];
        bad = !pte[PTE_A] || (!pte[PTE_D] && wr)
            || (priv == PRIV_USER && !pte[PTE_U])
            || (rd && !pte[PTE_R] && !pte[PTE_X])   // load on exec-only page is ok
            || (ex && !pte[PTE_X])
            || (wr && !pte[PTE_W]);
        res           = '0;
        res.kind      = KIND_DONE;
        res.fault     = bad;
        res.phys_addr = bad ? '0 : paddr;
        return res;
    endfunction

    assign e   = i_item.entry_word;
    assign ppn = e[ENTRY_W-1:PTE_PPN_LSB];
    assign v   = e[PTE_V];
    assign r   = e[PTE_R];
    assign w   = e[PTE_W];
    assign x   = e[PTE_X];

    always_comb begin
        n_phase  = r_phase;
        n_vaddr  = r_vaddr;
        n_access = r_access;
        n_priv   = r_priv;
        o_result = '0;
        if (i_item.func == FUNC_REQ) begin
            if (!i_item.trans_on) begin
                n_phase            = PH_IDLE;
                o_result.kind      = KIND_DONE;
                o_result.phys_addr = {2'b00, i_item.virt_addr};
            end else begin
                n_phase            = PH_L1;
                n_vaddr            = i_item.virt_addr;
                n_access           = {i_item.is_exec, i_item.is_write, i_item.is_read};
                n_priv             = i_item.privilege;
                o_result.kind      = KIND_READ;
                o_result.read_addr = {i_item.root_ppn, i_item.virt_addr[31:22], 2'b00};
            end
        end else begin
            n_phase        = PH_IDLE;
            o_result.kind  = KIND_DONE;
            o_result.fault = 1'b1;
            case (r_phase)
                PH_L1: begin
                    if (!v || (!r && w)) begin
                        o_result.fault = 1'b1;
                    end else if (r || x) begin
                        // superpage must be 4 MiB aligned
                        if (ppn[VPN_W-1:0] != '0) begin
                            o_result.fault = 1'b1;
                        end else begin
                            o_result = leaf_check(e, r_access, r_priv,
                                                  {ppn[PPN_W-1:VPN_W], r_vaddr[21:0]});
                        end
                    end else begin
                        n_phase            = PH_L2;
                        o_result           = '0;
                        o_result.kind      = KIND_READ;
                        o_result.read_addr = {ppn, r_vaddr[21:12], 2'b00};
                    end
                end
                PH_L2: begin
                    if (!v || (!r && w) || (!r && !x)) begin
                        o_result.fault = 1'b1;
                    end else begin
                        o_result = leaf_check(e, r_access, r_priv, {ppn, r_vaddr[11:0]});
                    end
                end
                default: begin
                    o_result.fault = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_vaddr  <= '0;
            r_access <= '0;
            r_priv   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_vaddr  <= n_vaddr;
            r_access <= n_access;
            r_priv   <= n_priv;
        end
    end

    `SV32PTW_ASSERT_NEXT(a_req_starts_walk, i_clk, i_rst_n,
        i_step && i_item.func == FUNC_REQ && i_item.trans_on, r_phase == PH_L1)
    `SV32PTW_ASSERT_NEXT(a_phase_holds, i_clk, i_rst_n,
        !i_step, $stable(r_phase) && $stable(r_vaddr))
    `SV32PTW_ASSERT_NOW(a_idle_rsp_faults, i_clk, i_rst_n,
        i_item.func == FUNC_RSP && r_phase == PH_IDLE, o_result.fault)
    `SV32PTW_ASSERT_NOW(a_fault_no_addr, i_clk, i_rst_n,
        o_result.fault, o_result.kind == KIND_DONE && o_result.phys_addr == '0)

endmodule

`default_nettype wire

@@ hw/rtl/sv32_page_table_walker.sv @@
// ----------------------------------------------------------------------------
// sv32_page_table_walker
// Two-level Sv32 translation walker with registered input and result stages.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries translate requests (func 0) and memory read responses
//   (func 1, entry word in entry_word). o_rsp carries one result per item:
//   a memory read request for the next page table entry (kind 0, read_addr)
//   or a finished translation (kind 1, phys_addr, fault).
//   The caller returns the entry for each read request as a func 1 item.
//   A new translate request in the middle of a walk drops that walk.
// Timing:
//   An item is taken into the input register and decided there; its result is
//   registered into the output register and appears on o_rsp. One item per
//   cycle is sustained while o_rsp.ready stays high; the walk state updates in
//   the same step as the decision.
// Reset: i_rst_n low clears both stage valids and returns the walk to idle.
// Stall: while o_rsp.ready is low the result holds; one more item waits in
//   the input register, after which i_req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sv32_page_table_walker
    import sv32ptw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sv32ptw_in_if.sink     i_req,
    sv32ptw_out_if.source  o_rsp
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result walk_result;
    logic    advance;
    logic    in_take;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.func       <= i_req.func;
            r_in_item.virt_addr  <= i_req.virt_addr;
            r_in_item.is_read    <= i_req.is_read;
            r_in_item.is_write   <= i_req.is_write;
            r_in_item.is_exec    <= i_req.is_exec;
            r_in_item.trans_on   <= i_req.trans_on;
            r_in_item.privilege  <= i_req.privilege;
            r_in_item.root_ppn   <= i_req.root_ppn;
            r_in_item.entry_word <= i_req.entry_word;
        end
    end

    sv32ptw_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (walk_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= walk_result;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.kind      = r_out.kind;
    assign o_rsp.read_addr = r_out.read_addr;
    assign o_rsp.phys_addr = r_out.phys_addr;
    assign o_rsp.fault     = r_out.fault;

endmodule

`default_nettype wire
